// ----- design/assert_macros.svh -----
// Assertion helpers for the transmit scheduler.
// Each macro expands to one labeled concurrent assertion, clocked on the rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge while reset is released.
`define ASSERT_HOLDS(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// The condition must never be true at a rising edge while reset is released.
`define ASSERT_NEVER(lbl, clk_sig, rst_n_sig, cond, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) !(cond)) else $error(msg);

`endif

// ----- design/cantx_pkg.sv -----
// Shared types and constants for the CAN transmit scheduler.
// Used by cantx_sched_core and the top level; depends on nothing else.
`default_nettype none

package cantx_pkg;

	localparam int FRAME_W = 64;
	localparam int INFO_W = 56;
	localparam int CNT_W = 24;
	localparam int CONF_CNT_W = 25;
	localparam int CFG_IDX_W = 1;

	localparam int INFO_BYTES_DEF = 7;

	// Item kinds.
	localparam logic [2:0] KIND_TICK = 3'd0;
	localparam logic [2:0] KIND_SET_PERIODIC = 3'd1;
	localparam logic [2:0] KIND_ONESHOT = 3'd2;
	localparam logic [2:0] KIND_DISABLE = 3'd3;
	localparam logic [2:0] KIND_CONFIRM = 3'd4;

	// Frame in flight.
	localparam logic [1:0] FLIGHT_NONE = 2'd0;
	localparam logic [1:0] FLIGHT_PERIODIC = 2'd1;
	localparam logic [1:0] FLIGHT_ONESHOT = 2'd2;

	// One-shot phases.
	localparam logic [1:0] PHASE_IDLE = 2'd0;
	localparam logic [1:0] PHASE_REQUESTED = 2'd1;
	localparam logic [1:0] PHASE_WAIT = 2'd2;

	// Controller answer to a write.
	localparam logic [1:0] WSTAT_ACCEPTED = 2'd0;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TICKS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_TIMEOUT = 1'b1;
	localparam logic [CNT_W-1:0] PERIOD_TICKS_RST = 24'd20000;
	localparam logic [CNT_W-1:0] CONFIRM_TIMEOUT_RST = 24'd200000;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] first_byte;
		logic [INFO_W-1:0] info_bytes;
		logic enable;
		logic [1:0] write_status;
	} item_t;

	typedef struct packed {
		logic write_attempt;
		logic [FRAME_W-1:0] frame_data;
		logic [1:0] attempt_kind;
		logic [1:0] in_flight_kind;
		logic [1:0] oneshot_status;
		logic confirmed_event;
		logic timeout_event;
		logic pending_held;
	} result_t;

endpackage

`default_nettype wire

// ----- design/cantx_sched_core.sv -----
// Scheduler state and the next-state logic that handles one word per step.
// Depends on cantx_pkg for the item and result types and the codes.
`default_nettype none

module cantx_sched_core #(
	parameter int INFO_BYTES = cantx_pkg::INFO_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step,
	input wire cantx_pkg::item_t item,
	input wire logic [cantx_pkg::CNT_W-1:0] period_ticks,
	input wire logic [cantx_pkg::CNT_W-1:0] confirm_timeout_ticks,
	output cantx_pkg::result_t result
);
	import cantx_pkg::*;

	localparam logic [INFO_W-1:0] INFO_MASK = (INFO_W'(1) << (8 * INFO_BYTES)) - INFO_W'(1);
	localparam logic [CONF_CNT_W-1:0] CONF_CNT_MAX = '1;

	logic [FRAME_W-1:0] periodic_frame_q, oneshot_frame_q, pending_frame_q;
	logic [FRAME_W-1:0] periodic_frame_n, oneshot_frame_n, pending_frame_n;
	logic pending_valid_q, pending_valid_n;
	logic periodic_enabled_q, periodic_enabled_n;
	logic [1:0] flight_kind_q, flight_kind_n;
	logic [1:0] oneshot_phase_q, oneshot_phase_n;
	logic [CNT_W-1:0] period_count_q, period_count_n;
	logic [CONF_CNT_W-1:0] confirm_count_q, confirm_count_n, confirm_count_inc;
	logic confirm_seen_q, confirm_seen_n;
	logic [FRAME_W-1:0] new_frame;
	logic accepted;

	assign new_frame = {item.info_bytes & INFO_MASK, item.first_byte};
	assign accepted = (item.write_status == WSTAT_ACCEPTED);
	assign confirm_count_inc = (confirm_count_q != CONF_CNT_MAX) ?
		confirm_count_q + CONF_CNT_W'(1) : confirm_count_q;

	always_comb begin
		periodic_frame_n = periodic_frame_q;
		oneshot_frame_n = oneshot_frame_q;
		pending_frame_n = pending_frame_q;
		pending_valid_n = pending_valid_q;
		periodic_enabled_n = periodic_enabled_q;
		flight_kind_n = flight_kind_q;
		oneshot_phase_n = oneshot_phase_q;
		period_count_n = period_count_q;
		confirm_count_n = confirm_count_q;
		confirm_seen_n = confirm_seen_q;
		result = '0;

		case (item.kind)
			KIND_TICK: begin
				// Retire or abandon the frame in flight first.
				if (flight_kind_q != FLIGHT_NONE) begin
					if (confirm_seen_q) begin
						result.confirmed_event = 1'b1;
						flight_kind_n = FLIGHT_NONE;
						confirm_count_n = '0;
						if (oneshot_phase_q == PHASE_WAIT) begin
							if (pending_valid_q) begin
								oneshot_frame_n = pending_frame_q;
								pending_valid_n = 1'b0;
								oneshot_phase_n = PHASE_REQUESTED;
							end else begin
								oneshot_phase_n = PHASE_IDLE;
							end
						end
					end else if (confirm_count_inc > {1'b0, confirm_timeout_ticks}) begin
						result.timeout_event = 1'b1;
						flight_kind_n = FLIGHT_NONE;
						confirm_count_n = '0;
						if (oneshot_phase_q == PHASE_WAIT) begin
							oneshot_phase_n = PHASE_REQUESTED;
						end
					end else begin
						confirm_count_n = confirm_count_inc;
					end
				end
				// Then at most one write attempt, one-shot first.
				if (flight_kind_n == FLIGHT_NONE) begin
					if (oneshot_phase_n == PHASE_REQUESTED) begin
						result.write_attempt = 1'b1;
						result.frame_data = oneshot_frame_n;
						result.attempt_kind = FLIGHT_ONESHOT;
						confirm_seen_n = 1'b0;
						if (accepted) begin
							flight_kind_n = FLIGHT_ONESHOT;
							oneshot_phase_n = PHASE_WAIT;
						end
					end else if (periodic_enabled_q) begin
						if (period_count_q < period_ticks) begin
							period_count_n = period_count_q + CNT_W'(1);
						end else begin
							period_count_n = '0;
							result.write_attempt = 1'b1;
							result.frame_data = periodic_frame_q;
							result.attempt_kind = FLIGHT_PERIODIC;
							confirm_seen_n = 1'b0;
							if (accepted) begin
								flight_kind_n = FLIGHT_PERIODIC;
							end
						end
					end else begin
						period_count_n = period_ticks;
					end
				end
			end
			KIND_SET_PERIODIC: begin
				periodic_frame_n = new_frame;
				periodic_enabled_n = item.enable;
			end
			KIND_ONESHOT: begin
				if (oneshot_phase_q == PHASE_IDLE) begin
					oneshot_frame_n = new_frame;
					oneshot_phase_n = PHASE_REQUESTED;
				end else begin
					// A newer request replaces whatever was queued.
					pending_frame_n = new_frame;
					pending_valid_n = 1'b1;
				end
			end
			KIND_DISABLE: begin
				periodic_enabled_n = 1'b0;
			end
			KIND_CONFIRM: begin
				confirm_seen_n = 1'b1;
			end
			default: begin
				// Unused kinds leave the state alone.
			end
		endcase

		result.in_flight_kind = flight_kind_n;
		result.oneshot_status = oneshot_phase_n;
		result.pending_held = pending_valid_n;
	end

	// Frame buffers are only read after being loaded, so they carry no reset.
	always_ff @(posedge clk) begin
		if (step) begin
			periodic_frame_q <= periodic_frame_n;
			oneshot_frame_q <= oneshot_frame_n;
			pending_frame_q <= pending_frame_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_valid_q <= 1'b0;
			periodic_enabled_q <= 1'b0;
			flight_kind_q <= FLIGHT_NONE;
			oneshot_phase_q <= PHASE_IDLE;
			period_count_q <= PERIOD_TICKS_RST;
			confirm_count_q <= '0;
			confirm_seen_q <= 1'b0;
		end else if (step) begin
			pending_valid_q <= pending_valid_n;
			periodic_enabled_q <= periodic_enabled_n;
			flight_kind_q <= flight_kind_n;
			oneshot_phase_q <= oneshot_phase_n;
			period_count_q <= period_count_n;
			confirm_count_q <= confirm_count_n;
			confirm_seen_q <= confirm_seen_n;
		end
	end

endmodule

`default_nettype wire

// ----- design/can_tx_periodic_oneshot_scheduler.sv -----
// CAN transmit scheduler top level: input register, scheduler core, result register.
// An accepted input word waits in the input register; its result word is offered from the
// result register once the word advances, which a stalled result holds off. Throughput is
// one word per cycle while out_stall is low; the core's single-pass next-state logic sets it.
// Reset (arst_n low, asynchronous) empties both registers, restores register defaults
// and returns the scheduler to idle with the period counter at the period reset value.
`default_nettype none
`include "assert_macros.svh"

module can_tx_periodic_oneshot_scheduler #(
	parameter int INFO_BYTES = cantx_pkg::INFO_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,

	// Configuration write port.
	input wire logic cfg_we,
	input wire logic [cantx_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [cantx_pkg::CNT_W-1:0] cfg_data,

	// Input channel.
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [2:0] kind,
	input wire logic [7:0] first_byte,
	input wire logic [cantx_pkg::INFO_W-1:0] info_bytes,
	input wire logic enable,
	input wire logic [1:0] write_status,

	// Output channel.
	output logic out_valid,
	input wire logic out_stall,
	output logic write_attempt,
	output logic [cantx_pkg::FRAME_W-1:0] frame_data,
	output logic [1:0] attempt_kind,
	output logic [1:0] in_flight_kind,
	output logic [1:0] oneshot_status,
	output logic confirmed_event,
	output logic timeout_event,
	output logic pending_held
);
	import cantx_pkg::*;

	logic [CNT_W-1:0] period_ticks_q;
	logic [CNT_W-1:0] confirm_timeout_ticks_q;

	item_t item_s1;
	logic valid_s1;
	result_t result_comb;
	result_t result_s2;
	logic valid_s2;
	logic advance;
	logic in_accept;

	// The staged word moves into the result register whenever that register is
	// empty or its word is being taken in the same cycle. The input register is
	// refilled in the same cycle it drains, so words stream without gaps.
	assign advance = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	// Configuration registers. Writes must arrive only while the scheduler is idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_ticks_q <= PERIOD_TICKS_RST;
			confirm_timeout_ticks_q <= CONFIRM_TIMEOUT_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_PERIOD_TICKS) begin
				period_ticks_q <= cfg_data;
			end else begin
				confirm_timeout_ticks_q <= cfg_data;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= '{kind: kind, first_byte: first_byte, info_bytes: info_bytes,
				enable: enable, write_status: write_status};
		end
	end

	// The core commits its state exactly when the staged word's result is captured.
	cantx_sched_core #(
		.INFO_BYTES(INFO_BYTES)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.item(item_s1),
		.period_ticks(period_ticks_q),
		.confirm_timeout_ticks(confirm_timeout_ticks_q),
		.result(result_comb)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_comb;
		end
	end

	assign out_valid = valid_s2;
	assign write_attempt = result_s2.write_attempt;
	assign frame_data = result_s2.frame_data;
	assign attempt_kind = result_s2.attempt_kind;
	assign in_flight_kind = result_s2.in_flight_kind;
	assign oneshot_status = result_s2.oneshot_status;
	assign confirmed_event = result_s2.confirmed_event;
	assign timeout_event = result_s2.timeout_event;
	assign pending_held = result_s2.pending_held;

	// A one-shot frame in flight always means the one-shot is waiting for confirmation.
	`ASSERT_HOLDS(a_oneshot_flight_phase, clk, arst_n, (valid_s2 && result_s2.in_flight_kind == FLIGHT_ONESHOT) |-> (result_s2.oneshot_status == PHASE_WAIT), "one-shot in flight without wait phase")
	// A single tick cannot both retire and abandon the frame in flight.
	`ASSERT_NEVER(a_confirm_xor_timeout, clk, arst_n, valid_s2 && result_s2.confirmed_event && result_s2.timeout_event, "confirmation and timeout in the same word")
	// An empty input register never holds off the sender.
	`ASSERT_HOLDS(a_no_stall_when_empty, clk, arst_n, !valid_s1 |-> !in_stall, "input stalled while the input register is empty")

endmodule

`default_nettype wire
